// ===== rtl/kbib_pkg.sv =====
// Shared types and constants for the k-mer block index builder.
// No dependencies.
package kbib_pkg;

    localparam int MAX_KEY_W = 24;   // code width at the largest supported k-mer length
    localparam int MAX_OFF_W = 20;   // in-block offset width at the largest block length
    localparam int KLEN_W    = 4;

    localparam logic [1:0] FUNC_CHAR    = 2'd0;
    localparam logic [1:0] FUNC_PREFIX  = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;
    localparam logic [1:0] FUNC_RESTART = 2'd3;

    localparam logic [1:0] KIND_FILL   = 2'd0;
    localparam logic [1:0] KIND_OFFSET = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] REG_KMER_LEN  = 2'd0;
    localparam logic [1:0] REG_GENOME    = 2'd1;
    localparam logic [1:0] REG_FILL_PASS = 2'd2;

    localparam logic [3:0] KMER_LEN_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  base_char;
        logic [15:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [31:0] out_address;
        logic [31:0] out_value;
    } result_t;

    typedef struct packed {
        logic [1:0]           op;
        logic [MAX_KEY_W-1:0] key;
        logic [KLEN_W-1:0]    span;
        logic [31:0]          blk;
        logic [MAX_OFF_W-1:0] off;
        logic [31:0]          base;
    } cmd_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] blk;
    } tag_t;

    typedef struct packed {
        logic clearing;
    } bk_status_t;

    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] c;
        case (ch)
            8'h41, 8'h61:               c = 3'd0;
            8'h43, 8'h63:               c = 3'd1;
            8'h47, 8'h67, 8'h4e, 8'h6e: c = 3'd2;
            8'h54, 8'h74:               c = 3'd3;
            default:                    c = 3'd4;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/kbib_queue.sv =====
// Four-entry command queue between front and back.
// Depends on kbib_pkg.
module kbib_queue
    import kbib_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic q_full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic q_empty
);
    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    cmd_t mem [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign q_full  = (cnt_reg == (PW+1)'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!wr_en && rd_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/kbib_front.sv =====
// Front end: accepts items, encodes bases, keeps the rolling code and position counters.
// Depends on kbib_pkg.
module kbib_front
    import kbib_pkg::*;
#(
    parameter int MAX_K     = 8,
    parameter int BLOCK_LEN = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   item,
    input  logic [3:0] kmer_len,
    input  logic [31:0] genome_length,
    input  bk_status_t bk_status,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_data
);
    localparam int CW = 2 * MAX_K;
    localparam int OFF_W = (BLOCK_LEN > 2) ? $clog2(BLOCK_LEN) : 1;
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BLOCK_LEN - 1);

    logic [CW-1:0]    roll_reg, roll_next;
    logic [31:0]      cp_reg, cp_next;
    logic [31:0]      blk_reg, blk_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [31:0]      base_reg, base_next;

    logic [3:0]    k;
    logic [CW-1:0] mask, roll_new;
    logic          accept, is_char, live, emit;

    assign full = q_full | bk_status.clearing;

    always_comb
    begin
        if (kmer_len < 4'd2)
        begin
            k = 4'd2;
        end
        else if (kmer_len > 4'(MAX_K))
        begin
            k = 4'(MAX_K);
        end
        else
        begin
            k = kmer_len;
        end
        for (int i = 0; i < CW; i++)
        begin
            mask[i] = (i < 2 * int'(k));
        end
        roll_new = ({roll_reg[CW-3:0], 2'b00} & mask) | CW'(base_code(item.base_char));

        accept  = push & ~full;
        is_char = (item.func == FUNC_CHAR);
        live    = (cp_reg < genome_length);
        emit    = accept & is_char & live & !(cp_reg < 32'(k - 4'd1));
        q_push  = accept & (!is_char | emit);

        q_data.op   = item.func;
        q_data.key  = is_char ? MAX_KEY_W'(roll_new) : MAX_KEY_W'(CW'(item.entry_index));
        q_data.span = k - 4'd1;
        q_data.blk  = blk_reg;
        q_data.off  = MAX_OFF_W'(off_reg);
        q_data.base = base_reg;

        roll_next = roll_reg;
        cp_next   = cp_reg;
        blk_next  = blk_reg;
        off_next  = off_reg;
        base_next = base_reg;
        if (accept && item.func == FUNC_RESTART)
        begin
            roll_next = '0;
            cp_next   = '0;
            blk_next  = '0;
            off_next  = '0;
            base_next = '0;
        end
        else if (accept && is_char && live)
        begin
            roll_next = roll_new;
            cp_next   = cp_reg + 32'd1;
            if (off_reg == OFF_LAST)
            begin
                off_next  = '0;
                blk_next  = blk_reg + 32'd1;
                base_next = base_reg + 32'(BLOCK_LEN);
            end
            else
            begin
                off_next = off_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg <= '0;
            cp_reg   <= '0;
            blk_reg  <= '0;
            off_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            roll_reg <= roll_next;
            cp_reg   <= cp_next;
            blk_reg  <= blk_next;
            off_reg  <= off_next;
            base_reg <= base_next;
        end
    end
endmodule

// ===== rtl/kbib_back.sv =====
// Back end: tag and table memories, start-block walk, prefix sum, result register.
// Depends on kbib_pkg.
module kbib_back
    import kbib_pkg::*;
#(
    parameter int MAX_K     = 8,
    parameter int BLOCK_LEN = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] genome_length,
    input  logic        fill_pass,
    input  cmd_t        q_data,
    input  logic        q_empty,
    output logic        q_pop,
    output bk_status_t  bk_status,
    output logic        empty,
    input  logic        pop,
    output result_t     result
);
    localparam int CW = 2 * MAX_K;
    localparam int DEPTH = 1 << CW;
    localparam int OFF_W = (BLOCK_LEN > 2) ? $clog2(BLOCK_LEN) : 1;
    localparam int CMPW = (OFF_W > KLEN_W) ? OFF_W : KLEN_W;
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BLOCK_LEN - 1);

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_ADJ, ST_TAG, ST_TBL} state_t;

    state_t            state_reg;
    logic              clr_table_reg;
    logic [CW-1:0]     clr_idx_reg;
    cmd_t              cmd_reg;
    logic [OFF_W-1:0]  s_off_reg;
    logic [KLEN_W-1:0] s_d_reg;
    logic [31:0]       s_blk_reg, s_base_reg;
    logic [31:0]       run_sum_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic [31:0] tbl_mem [DEPTH];
    tag_t        tag_mem [DEPTH];
    logic [31:0] tbl_q;
    tag_t        tag_q;

    logic          start, off_ge, full_blk, hit, rd_en, tbl_we, tag_we;
    logic [CW-1:0] rd_addr, wr_addr, key;
    logic [31:0]   tbl_wdata;
    tag_t          tag_wdata;
    logic [CMPW-1:0] off_x, d_x;

    assign empty  = ~out_valid_reg;
    assign result = out_reg;
    assign bk_status.clearing = (state_reg == ST_CLEAR);
    assign key = cmd_reg.key[CW-1:0];

    always_comb
    begin
        start    = (state_reg == ST_IDLE) && !q_empty && !out_valid_reg;
        q_pop    = start;
        off_x    = CMPW'(s_off_reg);
        d_x      = CMPW'(s_d_reg);
        off_ge   = (off_x >= d_x);
        full_blk = ({1'b0, s_base_reg} + 33'(BLOCK_LEN)) <= {1'b0, genome_length};
        hit      = tag_q.valid && (tag_q.blk == s_blk_reg);
        rd_en    = (start && (q_data.op inside {FUNC_PREFIX, FUNC_READ}))
                 || ((state_reg == ST_ADJ) && off_ge && full_blk);
        rd_addr  = (state_reg == ST_IDLE) ? q_data.key[CW-1:0] : key;

        tbl_we    = 1'b0;
        tag_we    = 1'b0;
        wr_addr   = key;
        tbl_wdata = tbl_q + 32'd1;
        tag_wdata.valid = 1'b1;
        tag_wdata.blk   = s_blk_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_we          = clr_table_reg;
                tag_we          = 1'b1;
                wr_addr         = clr_idx_reg;
                tbl_wdata       = '0;
                tag_wdata.valid = 1'b0;
            end
            ST_TAG:
            begin
                tbl_we = !hit;
                tag_we = !hit;
            end
            ST_TBL:
            begin
                tbl_we    = (cmd_reg.op == FUNC_PREFIX);
                tbl_wdata = run_sum_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[wr_addr] <= tbl_wdata;
        end
        if (tag_we)
        begin
            tag_mem[wr_addr] <= tag_wdata;
        end
        if (rd_en)
        begin
            tbl_q <= tbl_mem[rd_addr];
            tag_q <= tag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_table_reg <= 1'b1;
            clr_idx_reg   <= '0;
            run_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg    <= q_data;
                        s_off_reg  <= q_data.off[OFF_W-1:0];
                        s_d_reg    <= q_data.span;
                        s_blk_reg  <= q_data.blk;
                        s_base_reg <= q_data.base;
                        unique case (q_data.op) inside
                            FUNC_CHAR:
                            begin
                                state_reg <= ST_ADJ;
                            end
                            FUNC_PREFIX, FUNC_READ:
                            begin
                                state_reg <= ST_TBL;
                            end
                            default:
                            begin
                                run_sum_reg   <= '0;
                                clr_table_reg <= 1'b0;
                                clr_idx_reg   <= '0;
                                state_reg     <= ST_CLEAR;
                            end
                        endcase
                    end
                end
                ST_ADJ:
                begin
                    if (off_ge)
                    begin
                        state_reg <= full_blk ? ST_TAG : ST_IDLE;
                    end
                    else
                    begin
                        s_d_reg    <= KLEN_W'(d_x - off_x - 1'b1);
                        s_off_reg  <= OFF_LAST;
                        s_blk_reg  <= s_blk_reg - 32'd1;
                        s_base_reg <= s_base_reg - 32'(BLOCK_LEN);
                    end
                end
                ST_TAG:
                begin
                    if (!hit && fill_pass)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_reg.out_kind    <= KIND_FILL;
                        out_reg.out_address <= tbl_q;
                        out_reg.out_value   <= s_blk_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_TBL:
                begin
                    out_valid_reg       <= 1'b1;
                    out_reg.out_address <= 32'(key);
                    if (cmd_reg.op == FUNC_PREFIX)
                    begin
                        run_sum_reg       <= run_sum_reg + tbl_q;
                        out_reg.out_kind  <= KIND_OFFSET;
                        out_reg.out_value <= run_sum_reg;
                    end
                    else
                    begin
                        out_reg.out_kind  <= KIND_READ;
                        out_reg.out_value <= tbl_q;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/kmer_block_index_builder_unit.sv =====
// Top level: configuration registers, front end, command queue, back end.
// Depends on kbib_pkg, kbib_front, kbib_queue, kbib_back.
//
// Builds a per-block k-mer inverted index in two passes over the genome. After reset, and
// after every restart command, the back end sweeps its 4^MAX_K-entry tag memory one entry a
// cycle (after reset the count table too), while full stays high. In the back a k-mer steps
// back one block per block boundary between its start and the current position; then, in a
// full block, it reads its tag and count entry and updates them by read-modify-write, and in
// the partial last block it is dropped. Prefix and read commands read their table entry and
// return a result; characters before the first whole k-mer or past the end never reach the
// back. A four-entry queue lets the front keep accepting while the back works; one result
// register holds the oldest result.
module kmer_block_index_builder_unit
    import kbib_pkg::*;
#(
    parameter int BLOCK_LEN = 1024,
    parameter int MAX_K     = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [3:0]  kmer_len_reg;
    logic [31:0] genome_length_reg;
    logic        fill_pass_reg;

    logic       q_push, q_full, q_pop, q_empty;
    cmd_t       q_wdata, q_rdata;
    bk_status_t bk_status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_len_reg      <= KMER_LEN_RESET;
            genome_length_reg <= '0;
            fill_pass_reg     <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_KMER_LEN:  kmer_len_reg      <= pwdata[3:0];
                REG_GENOME:    genome_length_reg <= pwdata;
                REG_FILL_PASS: fill_pass_reg     <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_KMER_LEN:  prdata = {28'd0, kmer_len_reg};
            REG_GENOME:    prdata = genome_length_reg;
            REG_FILL_PASS: prdata = {31'd0, fill_pass_reg};
            default:       prdata = '0;
        endcase
    end

    kbib_front #(.MAX_K(MAX_K), .BLOCK_LEN(BLOCK_LEN)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .kmer_len      (kmer_len_reg),
        .genome_length (genome_length_reg),
        .bk_status     (bk_status),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    kbib_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .q_empty (q_empty)
    );

    kbib_back #(.MAX_K(MAX_K), .BLOCK_LEN(BLOCK_LEN)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .genome_length (genome_length_reg),
        .fill_pass     (fill_pass_reg),
        .q_data        (q_rdata),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .bk_status     (bk_status),
        .empty         (empty),
        .pop           (pop),
        .result        (result)
    );
endmodule

// ===== tb/kmer_block_index_builder_unit_tb.sv =====
// Self-checking testbench for kmer_block_index_builder_unit: directed table, then random
// count, prefix and fill passes checked against an in-bench k-mer index predictor.
// Depends on kbib_pkg and the RTL of kmer_block_index_builder_unit.
`timescale 1ns / 1ps

module kmer_block_index_builder_unit_tb;
    import kbib_pkg::*;

    localparam int BLOCK_LEN   = 1024;
    localparam int MAX_K       = 8;
    localparam int TABLE_DEPTH = 1 << (2 * MAX_K);
    localparam int SETTLE      = 60;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        in_item_t    it;
        logic        has_exp;
        result_t     exp;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    item;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [31:0] count_table [TABLE_DEPTH];
    logic        tag_valid [TABLE_DEPTH];
    logic [31:0] tag_block [TABLE_DEPTH];
    logic [31:0] roll_code;
    logic [31:0] char_pos;
    logic [31:0] offset_sum;
    logic [3:0]  cfg_klen;
    logic [31:0] cfg_genome;
    logic        cfg_fill;

    result_t  pending_results[$];
    dir_row_t dir_rows[$];
    logic [7:0] genome_seq[$];

    int  err_cnt;
    bit  quiet;
    bit  hold_now;

    kmer_block_index_builder_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [2:0] char_to_base(input logic [7:0] ch);
        case (ch)
            "A", "a":           return 3'd0;
            "C", "c":           return 3'd1;
            "G", "g", "N", "n": return 3'd2;
            "T", "t":           return 3'd3;
            default:            return 3'd4;
        endcase
    endfunction

    task automatic clear_pass();
        roll_code  = '0;
        char_pos   = '0;
        offset_sum = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            tag_valid[i] = 1'b0;
    endtask

    task automatic index_predict(input in_item_t it);
        logic [31:0] k;
        logic [31:0] mask;
        logic [31:0] start;
        logic [31:0] blk;
        logic [15:0] code;
        logic [15:0] entry;
        logic [31:0] cnt;
        entry = it.entry_index;
        case (it.func)
            FUNC_CHAR:
            begin
                if (char_pos >= cfg_genome)
                    return;
                k = (cfg_klen < 2) ? 2 : (cfg_klen > MAX_K) ? MAX_K : cfg_klen;
                mask = 32'hFFFF_FFFF >> (32 - 2 * k);
                roll_code = ((roll_code << 2) & mask) | char_to_base(it.base_char);
                code = roll_code[15:0];
                if (char_pos + 1 < k)
                begin
                    char_pos++;
                    return;
                end
                start = char_pos - (k - 1);
                char_pos++;
                blk = start / BLOCK_LEN;
                if (blk >= cfg_genome / BLOCK_LEN)
                    return;
                if (tag_valid[code] && tag_block[code] == blk)
                    return;
                tag_valid[code] = 1'b1;
                tag_block[code] = blk;
                if (cfg_fill)
                    pending_results.push_back('{KIND_FILL, count_table[code], blk});
                count_table[code] = count_table[code] + 1;
            end
            FUNC_PREFIX:
            begin
                cnt = count_table[entry];
                count_table[entry] = offset_sum;
                offset_sum = offset_sum + cnt;
                pending_results.push_back('{KIND_OFFSET, 32'(entry), count_table[entry]});
            end
            FUNC_READ:
                pending_results.push_back('{KIND_READ, 32'(entry), count_table[entry]});
            default:
                clear_pass();
        endcase
    endtask

    task automatic send_item(input in_item_t it, input logic has_exp, input result_t exp);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        push = 1'b1;
        item = it;
        do @(posedge clk); while (full);
        index_predict(it);
        if (has_exp)
        begin
            void'(pending_results.pop_back());
            pending_results.push_back(exp);
        end
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic send(input logic [1:0] func, input logic [7:0] ch, input logic [15:0] entry);
        send_item('{func, ch, entry}, 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_KMER_LEN:  cfg_klen   = val[3:0];
            REG_GENOME:    cfg_genome = val;
            REG_FILL_PASS: cfg_fill   = val[0];
            default:       ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic add_item(input logic [1:0] func, input logic [7:0] ch,
                            input logic [15:0] entry, input logic has_exp,
                            input logic [1:0] kind, input logic [31:0] addr,
                            input logic [31:0] val);
        dir_rows.push_back('{ROW_ITEM, '{func, ch, entry}, has_exp, '{kind, addr, val},
                             2'd0, 32'd0});
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [31:0] val);
        dir_rows.push_back('{ROW_CFG, '0, 1'b0, '0, idx, val});
    endtask

    task automatic random_char(output logic [7:0] ch);
        logic [7:0] acgt [4] = '{"A", "C", "G", "T"};
        if ($urandom_range(0, 7) == 0)
            ch = 8'($urandom_range(0, 255));
        else
            ch = acgt[$urandom_range(0, 3)];
    endtask

    // result side: random bursts of stall, one long hold-off on request
    initial
    begin
        int idle_cnt;
        result_t exp;
        idle_cnt = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_now)
            begin
                pop = 1'b0;
                repeat (400) @(negedge clk);
                hold_now = 1'b0;
            end
            if (idle_cnt > 0)
            begin
                pop = 1'b0;
                idle_cnt--;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                pop = 1'b0;
                idle_cnt = $urandom_range(1, 19) - 1;
            end
            else
                pop = 1'b1;
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected transfer: kind %0d addr %h value %h",
                                 result.out_kind, result.out_address, result.out_value);
                end
                else
                begin
                    exp = pending_results.pop_front();
                    if (result.out_kind !== exp.out_kind
                        || result.out_address !== exp.out_address
                        || result.out_value !== exp.out_value)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: exp kind %0d addr %h value %h, got %0d %h %h",
                                     exp.out_kind, exp.out_address, exp.out_value,
                                     result.out_kind, result.out_address, result.out_value);
                    end
                end
            end
        end
    end

    initial
    begin
        logic [7:0] ch;
        string      dna_chars;
        err_cnt  = 0;
        quiet    = 1'b0;
        hold_now = 1'b0;
        rst_n    = 1'b0;
        push     = 1'b0;
        item     = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            count_table[i] = '0;
            tag_block[i]   = '0;
        end
        clear_pass();
        cfg_klen   = KMER_LEN_RESET;
        cfg_genome = '0;
        cfg_fill   = 1'b0;
        dna_chars  = "ACGTNacgtn";

        add_item(FUNC_READ,   8'h00, 16'h0000, 1'b1, KIND_READ,   32'h0000, 32'd0);
        add_item(FUNC_READ,   8'h00, 16'hFFFF, 1'b1, KIND_READ,   32'hFFFF, 32'd0);
        add_item(FUNC_PREFIX, 8'h00, 16'h0000, 1'b1, KIND_OFFSET, 32'h0000, 32'd0);
        add_item(FUNC_CHAR,   "A",   16'h0000, 1'b0, KIND_FILL,   32'd0,    32'd0);
        add_item(FUNC_CHAR,   8'hFF, 16'hFFFF, 1'b0, KIND_FILL,   32'd0,    32'd0);
        add_item(FUNC_PREFIX, 8'h00, 16'hFFFF, 1'b1, KIND_OFFSET, 32'hFFFF, 32'd0);
        add_cfg(REG_KMER_LEN, 32'd1);
        add_cfg(REG_GENOME, 32'd1026);
        add_cfg(REG_FILL_PASS, 32'd1);
        add_item(FUNC_RESTART, 8'hFF, 16'hFFFF, 1'b0, KIND_FILL, 32'd0, 32'd0);
        for (int i = 0; i < dna_chars.len(); i++)
            add_item(FUNC_CHAR, dna_chars[i], 16'h0000, 1'b0, KIND_FILL, 32'd0, 32'd0);
        add_item(FUNC_CHAR, 8'h00, 16'h0000, 1'b0, KIND_FILL, 32'd0, 32'd0);
        add_item(FUNC_CHAR, "x",   16'h0000, 1'b0, KIND_FILL, 32'd0, 32'd0);
        add_item(FUNC_CHAR, 8'hFF, 16'h0000, 1'b0, KIND_FILL, 32'd0, 32'd0);
        add_item(FUNC_READ, 8'h00, 16'h0006, 1'b0, KIND_FILL, 32'd0, 32'd0);
        add_item(FUNC_PREFIX, 8'h00, 16'h0004, 1'b0, KIND_FILL, 32'd0, 32'd0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_drained();
                reg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
                send_item(dir_rows[i].it, dir_rows[i].has_exp, dir_rows[i].exp);
        end

        // counting pass, smallest k, one full block plus a partial one and chars past the end
        wait_drained();
        reg_write(REG_KMER_LEN, 32'd2);
        reg_write(REG_GENOME, 32'd1030 + $urandom_range(0, 20));
        reg_write(REG_FILL_PASS, 32'd0);
        send(FUNC_RESTART, 8'($urandom), 16'($urandom));
        for (int i = 0; i < 1060; i++)
        begin
            random_char(ch);
            genome_seq.push_back(ch);
            send(FUNC_CHAR, ch, 16'($urandom));
            if ($urandom_range(0, 29) == 0)
                send(FUNC_READ, 8'($urandom), 16'($urandom_range(0, 15)));
        end
        for (int e = 0; e < 16; e++)
            send(FUNC_PREFIX, 8'($urandom), 16'(e));

        // fill pass over the first 200 characters of the same genome
        wait_drained();
        reg_write(REG_FILL_PASS, 32'd1);
        send(FUNC_RESTART, 8'($urandom), 16'($urandom));
        for (int i = 0; i < 200; i++)
        begin
            send(FUNC_CHAR, genome_seq[i], 16'($urandom));
            if ($urandom_range(0, 19) == 0)
                send(FUNC_READ, 8'($urandom), 16'($urandom));
        end

        // long k, whole address space as genome, result side held off for a while
        wait_drained();
        reg_write(REG_KMER_LEN, 32'd15);
        reg_write(REG_GENOME, 32'hFFFF_FFFF);
        send(FUNC_RESTART, 8'($urandom), 16'($urandom));
        hold_now = 1'b1;
        for (int i = 0; i < 300; i++)
        begin
            random_char(ch);
            send(FUNC_CHAR, ch, 16'($urandom));
        end

        wait_drained();
        quiet = 1'b1;
        reg_write(REG_KMER_LEN, 32'd0);
        reg_write(REG_KMER_LEN, 32'd8);
        for (int i = 0; i < 40; i++)
        begin
            random_char(ch);
            send(FUNC_CHAR, ch, 16'($urandom));
        end
        for (int i = 0; i < 60; i++)
            send($urandom_range(0, 1) ? FUNC_READ : FUNC_PREFIX, 8'($urandom),
                 16'($urandom));

        wait_drained();
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/kbib_pkg.sv
rtl/kbib_queue.sv
rtl/kbib_front.sv
rtl/kbib_back.sv
rtl/kmer_block_index_builder_unit.sv
tb/kmer_block_index_builder_unit_tb.sv
